>>> hw/rtl/rpc_pkg.sv
// shared types and constants of the rectangle polygon clipper
package rpc_pkg;

   localparam int CoordW = 16;
   localparam int MaxOut = 12;
   localparam int OutCntW = $clog2(MaxOut + 1);

   typedef logic signed [CoordW-1:0] coord_type;

   typedef enum logic [1:0] {
      CSR_XMIN = 2'd0,
      CSR_XMAX = 2'd1,
      CSR_YMIN = 2'd2,
      CSR_YMAX = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      TK_VERT,
      TK_CLOSE,
      TK_END
   } tok_kind_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_MUL,
      CS_DIV,
      CS_FIX,
      CS_SEND
   } cell_state_type;

   typedef struct packed {
      coord_type vert_x;
      coord_type vert_y;
      logic      vert_last;
   } req_type;

   typedef struct packed {
      coord_type out_x;
      coord_type out_y;
      logic      out_last;
      logic      out_empty;
   } rsp_type;

   // token handed from cell to cell
   typedef struct packed {
      tok_kind_type kind;
      coord_type    x;
      coord_type    y;
   } tok_type;

endpackage

>>> hw/rtl/rect_polygon_clipper_top.sv
// top level of the rectangle polygon clipper: window registers, feeder, four cells, sink
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  rpc_pkg::req_type  (vert_x, vert_y, vert_last)
//   rsp       out        rsp_valid/rsp_stall  rpc_pkg::rsp_type  (out_x, out_y, out_last, out_empty)
//   csr       in         csr_valid/csr_ready  csr_index, csr_data (window edges)
//
// an item turns into a vertex token, a close token when last, and an end-of-step token
// a cell forwards an edge with no crossing directly; for a crossing it also forms the
// product, runs the 16-step serial divider and applies the rounding fix
// req_stall is high while the feeder still holds tokens of the previous item
// synchronous reset restores the default window and empties all cells
// a stalled rsp backs up through the cells to the feeder; csr_ready is always high
module rect_polygon_clipper_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  rpc_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rpc_pkg::rsp_type   rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  rpc_pkg::csr_index_type csr_index,
   input  rpc_pkg::coord_type csr_data
);
   import rpc_pkg::*;

   coord_type xmin_ff, xmax_ff, ymin_ff, ymax_ff;
   coord_type fx_ff, fy_ff;
   logic pv_ff, pv_in, pc_ff, pc_in, pe_ff, pe_in;
   logic [4:0] cv;
   logic [4:0] cr;
   tok_type ct [5];
   coord_type wc [4];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         xmin_ff <= coord_type'(441);
         xmax_ff <= coord_type'(1193);
         ymin_ff <= coord_type'(407);
         ymax_ff <= coord_type'(767);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_XMIN: xmin_ff <= csr_data;
            CSR_XMAX: xmax_ff <= csr_data;
            CSR_YMIN: ymin_ff <= csr_data;
            CSR_YMAX: ymax_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // feeder
   assign req_stall = pv_ff || pc_ff || pe_ff;

   always_comb begin
      pv_in = pv_ff;
      pc_in = pc_ff;
      pe_in = pe_ff;
      cv[0] = req_stall;
      ct[0] = '{kind: TK_END, x: fx_ff, y: fy_ff};
      if (pv_ff) begin
         ct[0].kind = TK_VERT;
      end else if (pc_ff) begin
         ct[0].kind = TK_CLOSE;
      end
      if (cr[0]) begin
         if (pv_ff) begin
            pv_in = 1'b0;
         end else if (pc_ff) begin
            pc_in = 1'b0;
         end else begin
            pe_in = 1'b0;
         end
      end
      if (req_valid && !req_stall) begin
         pv_in = 1'b1;
         pc_in = req_data.vert_last;
         pe_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         pc_ff <= 1'b0;
         pe_ff <= 1'b0;
      end else begin
         pv_ff <= pv_in;
         pc_ff <= pc_in;
         pe_ff <= pe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         fx_ff <= req_data.vert_x;
         fy_ff <= req_data.vert_y;
      end
   end

   assign wc[0] = xmin_ff;
   assign wc[1] = xmax_ff;
   assign wc[2] = ymax_ff;
   assign wc[3] = ymin_ff;

   for (genvar k = 0; k < 4; k++) begin : g_cell
      rpc_cell #(.KIND(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .win_c     (wc[k]),
         .in_valid  (cv[k]),
         .in_ready  (cr[k]),
         .in_tok    (ct[k]),
         .out_valid (cv[k+1]),
         .out_ready (cr[k+1]),
         .out_tok   (ct[k+1])
      );
   end

   rpc_sink u_sink (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cv[4]),
      .in_ready  (cr[4]),
      .in_tok    (ct[4]),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hw/rtl/rpc_cell.sv
// one clipping stage against a single window edge, with its own serial divider
module rpc_cell #(
   parameter int KIND = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  rpc_pkg::coord_type win_c,
   input  logic             in_valid,
   output logic             in_ready,
   input  rpc_pkg::tok_type in_tok,
   output logic             out_valid,
   input  logic             out_ready,
   output rpc_pkg::tok_type out_tok
);
   import rpc_pkg::*;

   localparam int W = CoordW;
   localparam int CntW = $clog2(W);
   localparam bit UseY = (KIND >= 2);

   cell_state_type state_ff, state_in;
   logic started_ff, started_in;
   coord_type first_x_ff, first_x_in, first_y_ff, first_y_in;
   coord_type prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   coord_type su_ff, su_in, sv_ff, sv_in;
   coord_type ex_ff, ex_in, ey_ff, ey_in;
   coord_type ix_ff, ix_in, iy_ff, iy_in;
   logic pend_i_ff, pend_i_in, pend_e_ff, pend_e_in, pend_t_ff, pend_t_in;
   tok_kind_type fkind_ff, fkind_in;
   logic [W-1:0] rem_ff, rem_in, q_ff, q_in, d_ff, d_in;
   logic neg_ff, neg_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic ov_ff, ov_in;
   tok_type otok_ff, otok_in;

   function automatic logic inside_f(coord_type u, coord_type c);
      logic r;
      case (KIND)
         0: r = u > c;
         1: r = u <= c;
         2: r = u < c;
         default: r = u > c;
      endcase
      return r;
   endfunction

   // edge arithmetic
   coord_type eu, ev, ecx, ecy;
   logic signed [W:0] dv, du, dd;
   logic [W-1:0] mdv, mdu;
   logic [2*W-1:0] prod;
   logic [W:0] r2;
   logic ge;
   logic signed [W+1:0] qs, t0, t;
   coord_type iv;
   logic free;

   always_comb begin
      eu = UseY ? ey_ff : ex_ff;
      ev = UseY ? ex_ff : ey_ff;
      dv = (W+1)'(ev) - (W+1)'(sv_ff);
      du = (W+1)'(su_ff) - (W+1)'(win_c);
      dd = (W+1)'(su_ff) - (W+1)'(eu);
      mdv = dv[W] ? W'(-dv) : W'(dv);
      mdu = du[W] ? W'(-du) : W'(du);
      prod = (2*W)'(mdv) * (2*W)'(mdu);
      r2 = {rem_ff, q_ff[W-1]};
      ge = r2 >= {1'b0, d_ff};
      qs = signed'({2'b00, q_ff});
      t0 = (W+2)'(sv_ff) + (neg_ff ? -qs : qs);
      t = t0;
      // truncate toward zero when the division left a remainder
      if (rem_ff != '0) begin
         if (neg_ff && t0 > 0) begin
            t = t0 - (W+2)'(1);
         end else if (!neg_ff && t0 < 0) begin
            t = t0 + (W+2)'(1);
         end
      end
      iv = W'(t);
   end

   always_comb begin
      state_in = state_ff;
      started_in = started_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      su_in = su_ff;
      sv_in = sv_ff;
      ex_in = ex_ff;
      ey_in = ey_ff;
      ix_in = ix_ff;
      iy_in = iy_ff;
      pend_i_in = pend_i_ff;
      pend_e_in = pend_e_ff;
      pend_t_in = pend_t_ff;
      fkind_in = fkind_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      d_in = d_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      ov_in = ov_ff && !out_ready;
      otok_in = otok_ff;
      ecx = in_tok.x;
      ecy = in_tok.y;
      in_ready = (state_ff == CS_IDLE);
      free = !ov_ff || out_ready;

      case (state_ff)
         CS_IDLE: begin
            if (in_valid) begin
               pend_i_in = 1'b0;
               pend_e_in = 1'b0;
               pend_t_in = 1'b0;
               fkind_in = in_tok.kind;
               if (in_tok.kind == TK_CLOSE) begin
                  ecx = first_x_ff;
                  ecy = first_y_ff;
               end
               su_in = UseY ? prev_y_ff : prev_x_ff;
               sv_in = UseY ? prev_x_ff : prev_y_ff;
               ex_in = ecx;
               ey_in = ecy;
               case (in_tok.kind)
                  TK_VERT: begin
                     prev_x_in = in_tok.x;
                     prev_y_in = in_tok.y;
                     if (!started_ff) begin
                        started_in = 1'b1;
                        first_x_in = in_tok.x;
                        first_y_in = in_tok.y;
                     end else begin
                        pend_e_in = inside_f(UseY ? ecy : ecx, win_c);
                        if (inside_f(UseY ? prev_y_ff : prev_x_ff, win_c) != pend_e_in) begin
                           state_in = CS_MUL;
                        end else begin
                           state_in = CS_SEND;
                        end
                     end
                  end
                  TK_CLOSE: begin
                     pend_t_in = 1'b1;
                     started_in = 1'b0;
                     state_in = CS_SEND;
                     if (started_ff) begin
                        pend_e_in = inside_f(UseY ? ecy : ecx, win_c);
                        if (inside_f(UseY ? prev_y_ff : prev_x_ff, win_c) != pend_e_in) begin
                           state_in = CS_MUL;
                        end
                     end
                  end
                  default: begin
                     pend_t_in = 1'b1;
                     state_in = CS_SEND;
                  end
               endcase
            end
         end
         CS_MUL: begin
            {rem_in, q_in} = prod;
            d_in = W'(dd[W] ? -dd : dd);
            neg_in = dv[W] ^ du[W] ^ dd[W];
            cnt_in = CntW'(W - 1);
            state_in = CS_DIV;
         end
         CS_DIV: begin
            rem_in = ge ? W'(r2 - {1'b0, d_ff}) : W'(r2);
            q_in = {q_ff[W-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = CS_FIX;
            end
         end
         CS_FIX: begin
            ix_in = UseY ? iv : win_c;
            iy_in = UseY ? win_c : iv;
            pend_i_in = 1'b1;
            state_in = CS_SEND;
         end
         CS_SEND: begin
            if (free) begin
               // intersection first, then end point, then the forwarded marker
               if (pend_i_ff) begin
                  ov_in = 1'b1;
                  otok_in = '{kind: TK_VERT, x: ix_ff, y: iy_ff};
                  pend_i_in = 1'b0;
               end else if (pend_e_ff) begin
                  ov_in = 1'b1;
                  otok_in = '{kind: TK_VERT, x: ex_ff, y: ey_ff};
                  pend_e_in = 1'b0;
               end else if (pend_t_ff) begin
                  ov_in = 1'b1;
                  otok_in = '{kind: fkind_ff, x: '0, y: '0};
                  pend_t_in = 1'b0;
               end
               if (!pend_i_in && !pend_e_in && !pend_t_in) begin
                  state_in = CS_IDLE;
               end
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         started_ff <= 1'b0;
         pend_i_ff <= 1'b0;
         pend_e_ff <= 1'b0;
         pend_t_ff <= 1'b0;
         ov_ff <= 1'b0;
         first_x_ff <= '0;
         first_y_ff <= '0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
      end else begin
         state_ff <= state_in;
         started_ff <= started_in;
         pend_i_ff <= pend_i_in;
         pend_e_ff <= pend_e_in;
         pend_t_ff <= pend_t_in;
         ov_ff <= ov_in;
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
      end
   end

   always_ff @(posedge clock) begin
      su_ff <= su_in;
      sv_ff <= sv_in;
      ex_ff <= ex_in;
      ey_ff <= ey_in;
      ix_ff <= ix_in;
      iy_ff <= iy_in;
      fkind_ff <= fkind_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      d_ff <= d_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      otok_ff <= otok_in;
   end

   assign out_valid = ov_ff;
   assign out_tok = otok_ff;

`ifndef ASSERT_OFF
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == CS_DIV |-> d_ff != '0)
      else $error("divider running with zero divisor");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !out_ready |=> ov_ff && $stable(otok_ff))
      else $error("stalled token changed");
   a_fix_send: assert property (@(posedge clock) disable iff (reset)
      state_ff == CS_FIX |=> state_ff == CS_SEND && pend_i_ff)
      else $error("intersection not queued after divide");
`endif

endmodule

>>> hw/rtl/rpc_sink.sv
// output end of the chain: holds back one vertex, marks last and empty, limits count
module rpc_sink (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rpc_pkg::tok_type in_tok,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rpc_pkg::rsp_type rsp_data
);
   import rpc_pkg::*;

   logic held_v_ff, held_v_in;
   coord_type held_x_ff, held_x_in, held_y_ff, held_y_in;
   logic [OutCntW-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic put;
   rsp_type put_data;
   logic take;

   always_comb begin
      in_ready = !rsp_valid_ff || !rsp_stall;
      take = in_valid && in_ready;
      held_v_in = held_v_ff;
      held_x_in = held_x_ff;
      held_y_in = held_y_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      put = 1'b0;
      put_data = '{out_x: held_x_ff, out_y: held_y_ff, out_last: 1'b0, out_empty: 1'b0};
      if (take) begin
         case (in_tok.kind)
            TK_VERT: begin
               put = held_v_ff;
               held_v_in = 1'b1;
               held_x_in = in_tok.x;
               held_y_in = in_tok.y;
            end
            TK_CLOSE: begin
               put = 1'b1;
               put_data.out_last = 1'b1;
               if (!held_v_ff) begin
                  put_data = '{out_x: '0, out_y: '0, out_last: 1'b1, out_empty: 1'b1};
               end
               held_v_in = 1'b0;
            end
            default: begin
               cnt_in = '0;
            end
         endcase
      end
      // the last slot of a step is kept for the closing item
      if (put && cnt_ff < OutCntW'(MaxOut)
          && (put_data.out_last || cnt_ff < OutCntW'(MaxOut - 1))) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = put_data;
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_v_ff <= 1'b0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_v_ff <= held_v_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_x_ff <= held_x_in;
      held_y_ff <= held_y_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

`ifndef ASSERT_OFF
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.out_empty |-> rsp_data_ff.out_last)
      else $error("empty item without last");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= OutCntW'(MaxOut))
      else $error("item count overran");
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      take && in_tok.kind == TK_END |=> cnt_ff == '0)
      else $error("count not cleared at end of step");
`endif

endmodule
